// ===== design/jdbs_pkg.sv =====
`default_nettype none

package jdbs_pkg;

  // Event codes carried in the command field
  typedef enum logic [2:0] {
    CMD_RUN_START = 3'd0,
    CMD_RUN_CONT  = 3'd1,
    CMD_RUN_BAD   = 3'd2,
    CMD_IRQ       = 3'd3,
    CMD_CONV_DONE = 3'd4
  } cmd_e;

  // Run outcome codes
  typedef enum logic [1:0] {
    OUT_ERROR  = 2'd0,
    OUT_END    = 2'd1,
    OUT_RELOAD = 2'd2
  } outcome_e;

  // Decoder interrupt bits
  localparam logic [14:0] IRQ_CLEAR_MASK = 15'h5C68;
  localparam logic [14:0] IRQ_HEADER     = 15'h0008;
  localparam logic [14:0] IRQ_ERROR      = 15'h0020;
  localparam logic [14:0] IRQ_DONE       = 15'h0040;
  localparam logic [14:0] IRQ_LINE0      = 15'h0800;
  localparam logic [14:0] IRQ_LINE1      = 15'h1000;
  localparam logic [14:0] IRQ_RELOAD     = 15'h4000;

  typedef struct packed {
    logic [2:0]  command;
    logic [1:0]  loaded_buffers;
    logic        reload_mode;
    logic [14:0] irq_status;
    logic [31:0] decode_error;
  } item_t;

  typedef struct packed {
    logic        issue_start;
    logic        issue_end;
    logic        issue_line_continue;
    logic        issue_read_restart;
    logic [14:0] int_clear;
    logic        convert_start;
    logic        convert_buffer;
    logic        run_ready;
    logic [1:0]  run_outcome;
    logic [31:0] error_code;
    logic [1:0]  reload_mask;
    logic        bad_request;
  } result_t;

endpackage

`default_nettype wire

// ===== design/jpeg_decode_buffer_sequencer_top.sv =====
`default_nettype none

// Channel | Handshake                | Payload
// --------+--------------------------+------------------------------------------
// input   | in_valid_i / in_stall_o  | command, loaded_buffers, reload_mode,
//         |                          | irq_status, decode_error
// output  | out_valid_o / out_stall_i| issue_*, int_clear, convert_*, run_*,
//         |                          | error_code, reload_mask, bad_request
//
// One item per cycle sustained while out_stall_i is low; an accepted item
// passes the input register, then one pass of event logic into the result
// register, before it appears on the outputs. Reset clears all sequencer
// state and both valid flags. With the result register held by out_stall_i,
// one more item is taken into the input register before in_stall_o rises.

module jpeg_decode_buffer_sequencer_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  command_i,
  input  wire logic [1:0]  loaded_buffers_i,
  input  wire logic        reload_mode_i,
  input  wire logic [14:0] irq_status_i,
  input  wire logic [31:0] decode_error_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             issue_start_o,
  output logic             issue_end_o,
  output logic             issue_line_continue_o,
  output logic             issue_read_restart_o,
  output logic [14:0]      int_clear_o,
  output logic             convert_start_o,
  output logic             convert_buffer_o,
  output logic             run_ready_o,
  output logic [1:0]       run_outcome_o,
  output logic [31:0]      error_code_o,
  output logic [1:0]       reload_mask_o,
  output logic             bad_request_o
);
  import jdbs_pkg::*;

  logic    in_valid_q, in_valid_d;
  item_t   item_q;
  logic    out_valid_q, out_valid_d;
  result_t result_q;
  result_t result;
  logic    out_blocked;
  logic    advance;
  logic    in_accept;

  // Handshake control
  assign out_blocked = out_valid_q && out_stall_i;
  assign advance     = in_valid_q && !out_blocked;
  assign in_stall_o  = in_valid_q && out_blocked;
  assign in_accept   = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= '{command:        command_i,
                  loaded_buffers: loaded_buffers_i,
                  reload_mode:    reload_mode_i,
                  irq_status:     irq_status_i,
                  decode_error:   decode_error_i};
    end
    if (advance) begin
      result_q <= result;
    end
  end

  // Event logic and sequencer state
  jdbs_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (item_q),
    .result_o  (result)
  );

  assign out_valid_o           = out_valid_q;
  assign issue_start_o         = result_q.issue_start;
  assign issue_end_o           = result_q.issue_end;
  assign issue_line_continue_o = result_q.issue_line_continue;
  assign issue_read_restart_o  = result_q.issue_read_restart;
  assign int_clear_o           = result_q.int_clear;
  assign convert_start_o       = result_q.convert_start;
  assign convert_buffer_o      = result_q.convert_buffer;
  assign run_ready_o           = result_q.run_ready;
  assign run_outcome_o         = result_q.run_outcome;
  assign error_code_o          = result_q.error_code;
  assign reload_mask_o         = result_q.reload_mask;
  assign bad_request_o         = result_q.bad_request;

  // Checks
  a_bad_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_request_o |-> !run_ready_o && !issue_start_o && !convert_start_o)
    else $error("rejected request produced other outputs");

  a_reload_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && run_ready_o && run_outcome_o == OUT_RELOAD |-> reload_mask_o != 2'd0)
    else $error("reload outcome with empty mask");

  a_conv_buf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !convert_start_o |-> !convert_buffer_o)
    else $error("converter buffer set without converter start");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_o)
    else $error("evaluated item did not reach the result register");

endmodule

`default_nettype wire

// ===== design/jdbs_core.sv =====
`default_nettype none

module jdbs_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             advance_i,
  input  wire jdbs_pkg::item_t  item_i,
  output jdbs_pkg::result_t     result_o
);
  import jdbs_pkg::*;

  // Sequencer state
  logic [1:0]  full_inputs_q, full_inputs_d;
  logic        input_index_q, input_index_d;
  logic [31:0] latched_error_q, latched_error_d;
  logic        reading_q, reading_d;
  logic        writing_q, writing_d;
  logic        image_done_q, image_done_d;
  logic [1:0]  full_lines_q, full_lines_d;
  logic        dec_line_q, dec_line_d;
  logic        past_first_q, past_first_d;
  logic        conv_line_q, conv_line_d;
  logic        conv_busy_q, conv_busy_d;
  logic        reload_wanted_q, reload_wanted_d;

  result_t res;
  logic    skip_ready;

  // Event evaluation: next state and result in one pass
  always_comb begin
    full_inputs_d   = full_inputs_q;
    input_index_d   = input_index_q;
    latched_error_d = latched_error_q;
    reading_d       = reading_q;
    writing_d       = writing_q;
    image_done_d    = image_done_q;
    full_lines_d    = full_lines_q;
    dec_line_d      = dec_line_q;
    past_first_d    = past_first_q;
    conv_line_d     = conv_line_q;
    conv_busy_d     = conv_busy_q;
    reload_wanted_d = reload_wanted_q;
    res             = '0;
    skip_ready      = 1'b0;

    case (item_i.command)
      CMD_RUN_BAD: begin
        res.bad_request = 1'b1;
        skip_ready      = 1'b1;
      end
      CMD_RUN_START: begin
        past_first_d    = 1'b0;
        image_done_d    = 1'b0;
        latched_error_d = '0;
        writing_d       = 1'b1;
        dec_line_d      = 1'b0;
        full_lines_d    = '0;
        input_index_d   = 1'b0;
        full_inputs_d   = item_i.loaded_buffers;
        conv_line_d     = 1'b0;
        conv_busy_d     = 1'b0;
        reload_wanted_d = item_i.reload_mode;
        res.issue_start = 1'b1;
        reading_d       = (item_i.loaded_buffers != 2'd0);
        res.issue_read_restart = (item_i.loaded_buffers != 2'd0);
      end
      CMD_RUN_CONT: begin
        full_inputs_d   = full_inputs_q | item_i.loaded_buffers;
        reload_wanted_d = item_i.reload_mode;
        if (full_inputs_d != 2'd0 && !reading_q) begin
          reading_d              = 1'b1;
          res.issue_read_restart = 1'b1;
        end
      end
      CMD_IRQ: begin
        res.int_clear = ~item_i.irq_status & IRQ_CLEAR_MASK;
        if ((item_i.irq_status & (IRQ_HEADER | IRQ_ERROR | IRQ_DONE)) != '0) begin
          res.issue_end = 1'b1;
        end
        if ((item_i.irq_status & IRQ_ERROR) != '0) begin
          latched_error_d = item_i.decode_error;
        end
        if ((item_i.irq_status & IRQ_DONE) != '0) begin
          image_done_d = 1'b1;
        end
        // A line buffer was filled by the decoder
        if ((item_i.irq_status & (IRQ_LINE0 | IRQ_LINE1)) != '0) begin
          full_lines_d[dec_line_q] = 1'b1;
          dec_line_d               = ~dec_line_q;
          if (full_lines_d != 2'b11) begin
            writing_d               = 1'b1;
            res.issue_line_continue = past_first_q;
          end else begin
            writing_d = 1'b0;
          end
          past_first_d = 1'b1;
          if (!conv_busy_q) begin
            conv_busy_d        = 1'b1;
            res.convert_start  = 1'b1;
            res.convert_buffer = conv_line_q;
          end
        end
        // An input buffer was consumed
        if ((item_i.irq_status & IRQ_RELOAD) != '0) begin
          full_inputs_d[input_index_q] = 1'b0;
          input_index_d                = ~input_index_q;
          reading_d                    = (full_inputs_d != 2'd0);
          res.issue_read_restart       = (full_inputs_d != 2'd0);
        end
      end
      CMD_CONV_DONE: begin
        full_lines_d[conv_line_q] = 1'b0;
        if (!writing_q && !image_done_q && latched_error_q == '0 &&
            full_inputs_q != 2'd0) begin
          writing_d               = 1'b1;
          res.issue_line_continue = 1'b1;
        end
        conv_line_d = ~conv_line_q;
        if (full_lines_d != 2'd0) begin
          conv_busy_d        = 1'b1;
          res.convert_start  = 1'b1;
          res.convert_buffer = ~conv_line_q;
        end else begin
          conv_busy_d = 1'b0;
        end
      end
      default: ;
    endcase

    // Run waiter check on the updated state
    if (!skip_ready &&
        ((image_done_d && full_lines_d == 2'd0) || latched_error_d != '0 ||
         (full_inputs_d != 2'b11 && reload_wanted_d))) begin
      res.run_ready = 1'b1;
      if (latched_error_d != '0) begin
        res.run_outcome = OUT_ERROR;
        res.error_code  = latched_error_d;
      end else if (image_done_d) begin
        res.run_outcome = OUT_END;
      end else begin
        res.run_outcome = OUT_RELOAD;
        res.reload_mask = full_inputs_d ^ 2'b11;
      end
    end
  end

  assign result_o = res;

  // State update when the item moves to the result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_inputs_q   <= '0;
      input_index_q   <= 1'b0;
      latched_error_q <= '0;
      reading_q       <= 1'b0;
      writing_q       <= 1'b0;
      image_done_q    <= 1'b0;
      full_lines_q    <= '0;
      dec_line_q      <= 1'b0;
      past_first_q    <= 1'b0;
      conv_line_q     <= 1'b0;
      conv_busy_q     <= 1'b0;
      reload_wanted_q <= 1'b0;
    end else if (advance_i) begin
      full_inputs_q   <= full_inputs_d;
      input_index_q   <= input_index_d;
      latched_error_q <= latched_error_d;
      reading_q       <= reading_d;
      writing_q       <= writing_d;
      image_done_q    <= image_done_d;
      full_lines_q    <= full_lines_d;
      dec_line_q      <= dec_line_d;
      past_first_q    <= past_first_d;
      conv_line_q     <= conv_line_d;
      conv_busy_q     <= conv_busy_d;
      reload_wanted_q <= reload_wanted_d;
    end
  end

endmodule

`default_nettype wire
